// ===== sv/irfalu_pkg.sv =====
// Shared types and operation codes for the integer register file ALU.
`default_nettype none

package irfalu_pkg;

    // Data path, iteration, func, store size and register select widths.
    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;
    localparam int FUNC_W = 4;
    localparam int SIZE_W = 2;
    localparam int SEL_W  = 4;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [SIZE_W-1:0] size_t;

    // Arithmetic kind in the low two bits of func.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Whole func codes.
    localparam func_t FUNC_STORE = 4'd8;

    // Store widths.
    localparam size_t SIZE_BYTE = 2'd0;
    localparam size_t SIZE_HALF = 2'd1;
    localparam size_t SIZE_WORD = 2'd2;
    localparam size_t SIZE_BAD  = 2'd3;

endpackage

`default_nettype wire

// ===== sv/integer_register_file_alu.sv =====
// Integer register file with a shared iterative ALU and a store read-out channel.
//
// Items arrive on the s_ channel (valid/ready) and each produces exactly one
// result item on the m_ channel (valid/ready). The block works on one item at
// a time: s_ready is high only while the sequencer is idle. Every item reads
// its first register, then (for arithmetic) its second source, through the
// single registered read port of the register memory. Add and subtract pass
// once through the shared 33-bit adder; multiply (shift and add) and unsigned
// divide (restoring) pass through it 32 times, one bit per cycle.
// An accepted item passes through the first read state, then, for arithmetic,
// the second read and run states, and ends in the final state, which loads the
// result and returns the sequencer to idle, where the next item can be accepted.
// The result sits in an output register, so a new item is accepted while it
// waits; if the receiver still stalls when the next result is ready, the
// sequencer holds in its final state until the output register frees.
// Reset (aresetn low, synchronous) clears all registers to zero through per
// entry valid bits, clears store_enable and empties the output register.
// The user writes store_enable through cfg_wr_en/cfg_wr_data only while idle;
// the block itself does not enforce this.
`default_nettype none

module integer_register_file_alu #(
    parameter int REGISTER_COUNT = 16
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // Configuration
    input  wire                               cfg_wr_en,
    input  wire                               cfg_wr_data,
    // Input items
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  [irfalu_pkg::FUNC_W-1:0]     s_func,
    input  wire  [irfalu_pkg::SEL_W-1:0]      s_first_reg,
    input  wire  [irfalu_pkg::SEL_W-1:0]      s_second_reg,
    input  wire  [irfalu_pkg::DATA_W-1:0]     s_operand,
    input  wire  [irfalu_pkg::SIZE_W-1:0]     s_store_width,
    // Result items
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [irfalu_pkg::DATA_W-1:0]     m_store_value,
    output logic [irfalu_pkg::DATA_W-1:0]     m_store_address,
    output logic                              m_store_valid,
    output logic                              m_divide_by_zero,
    output logic                              m_bad_operation
);

    localparam int DW    = irfalu_pkg::DATA_W;
    localparam int IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam int SEL_N = 1 << irfalu_pkg::SEL_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD_A = 3'd1;
    localparam logic [2:0] ST_RD_B = 3'd2;
    localparam logic [2:0] ST_RUN  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // Register indices are reduced modulo the file size by a constant table.
    logic [IDX_W-1:0] slot_lut [SEL_N];
    for (genvar i = 0; i < SEL_N; i++) begin : g_slot
        assign slot_lut[i] = IDX_W'(i % REGISTER_COUNT);
    end

    // Control registers.
    logic [2:0]                    state_reg, state_next;
    logic [irfalu_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          store_enable_reg;
    logic [REGISTER_COUNT-1:0]     valid_reg;

    // Item and data path registers.
    irfalu_pkg::func_t             func_reg, func_next;
    irfalu_pkg::size_t             vsize_reg, vsize_next;
    logic [IDX_W-1:0]              a_idx_reg, a_idx_next;
    logic [IDX_W-1:0]              b_idx_reg, b_idx_next;
    irfalu_pkg::word_t             operand_reg, operand_next;
    irfalu_pkg::word_t             pa_reg, pa_next;
    irfalu_pkg::word_t             pb_reg, pb_next;
    irfalu_pkg::word_t             acc_reg, acc_next;

    // Result registers.
    irfalu_pkg::word_t             sval_reg, sval_next;
    irfalu_pkg::word_t             saddr_reg, saddr_next;
    logic                          svalid_reg, svalid_next;
    logic                          dz_reg, dz_next;
    logic                          bad_reg, bad_next;

    // Register memory with one write and one registered read port.
    irfalu_pkg::word_t             mem [REGISTER_COUNT];
    irfalu_pkg::word_t             rd_data_reg;
    logic                          rd_hit_reg;
    logic [IDX_W-1:0]              rd_addr;
    logic                          mem_we;
    irfalu_pkg::word_t             rd_word;
    irfalu_pkg::word_t             result_word;

    // Item decode.
    logic                          is_arith;
    logic                          is_store;
    logic [1:0]                    op_kind;

    // Shared adder and subtractor.
    logic [DW:0]                   unit_a;
    logic [DW:0]                   unit_b;
    logic                          unit_sub;
    logic [DW+1:0]                 unit_sum;
    logic                          no_borrow;

    assign op_kind  = func_reg[1:0];
    assign is_arith = !func_reg[irfalu_pkg::FUNC_W-1];
    assign is_store = (func_reg == irfalu_pkg::FUNC_STORE) && (vsize_reg != irfalu_pkg::SIZE_BAD);

    // The first register is addressed straight from the input while idle.
    assign rd_addr = (state_reg == ST_IDLE) ? slot_lut[s_first_reg] : b_idx_reg;

    // An entry that was never written since reset reads as zero.
    assign rd_word = rd_hit_reg ? rd_data_reg : '0;

    assign result_word = (op_kind == irfalu_pkg::OP_DIV) ? pa_reg : acc_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[a_idx_reg] <= result_word;
        end
        rd_data_reg <= mem[rd_addr];
        rd_hit_reg  <= valid_reg[rd_addr];
    end

    // Operand selection for the shared adder.
    always_comb begin
        unit_a   = {1'b0, pa_reg};
        unit_b   = {1'b0, pb_reg};
        unit_sub = 1'b0;
        case (op_kind)
            irfalu_pkg::OP_ADD: begin
                unit_sub = 1'b0;
            end
            irfalu_pkg::OP_SUB: begin
                unit_sub = 1'b1;
            end
            irfalu_pkg::OP_MUL: begin
                unit_a = {1'b0, acc_reg};
                unit_b = pb_reg[0] ? {1'b0, pa_reg} : '0;
            end
            default: begin
                unit_a   = {acc_reg, pa_reg[DW-1]};
                unit_b   = {1'b0, pb_reg};
                unit_sub = 1'b1;
            end
        endcase
        unit_sum  = {1'b0, unit_a} + {1'b0, (unit_sub ? ~unit_b : unit_b)}
                  + (DW+2)'(unit_sub);
        no_borrow = unit_sum[DW+1];
    end

    // Sequencer and data path next state.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        func_next    = func_reg;
        vsize_next   = vsize_reg;
        a_idx_next   = a_idx_reg;
        b_idx_next   = b_idx_reg;
        operand_next = operand_reg;
        pa_next      = pa_reg;
        pb_next      = pb_reg;
        acc_next     = acc_reg;
        sval_next    = sval_reg;
        saddr_next   = saddr_reg;
        svalid_next  = svalid_reg;
        dz_next      = dz_reg;
        bad_next     = bad_reg;
        mem_we       = 1'b0;

        // The receiver takes the waiting result.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next    = s_func;
                    vsize_next   = s_store_width;
                    a_idx_next   = slot_lut[s_first_reg];
                    b_idx_next   = slot_lut[s_second_reg];
                    operand_next = s_operand;
                    state_next   = ST_RD_A;
                end
            end
            ST_RD_A: begin
                pa_next    = rd_word;
                state_next = is_arith ? ST_RD_B : ST_DONE;
            end
            ST_RD_B: begin
                pb_next    = func_reg[2] ? operand_reg : rd_word;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                case (op_kind)
                    irfalu_pkg::OP_MUL: begin
                        acc_next = unit_sum[DW-1:0];
                        pa_next  = {pa_reg[DW-2:0], 1'b0};
                        pb_next  = {1'b0, pb_reg[DW-1:1]};
                    end
                    irfalu_pkg::OP_DIV: begin
                        acc_next = no_borrow ? unit_sum[DW-1:0]
                                             : {acc_reg[DW-2:0], pa_reg[DW-1]};
                        pa_next  = {pa_reg[DW-2:0], no_borrow};
                    end
                    default: begin
                        acc_next = unit_sum[DW-1:0];
                    end
                endcase
                cnt_next = cnt_reg + 1'b1;
                if ((op_kind == irfalu_pkg::OP_ADD) || (op_kind == irfalu_pkg::OP_SUB)
                        || (cnt_reg == irfalu_pkg::CNT_W'(DW - 1))) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    sval_next    = '0;
                    saddr_next   = '0;
                    svalid_next  = 1'b0;
                    dz_next      = 1'b0;
                    bad_next     = 1'b0;
                    if (is_arith) begin
                        mem_we  = 1'b1;
                        dz_next = (op_kind == irfalu_pkg::OP_DIV) && (pb_reg == '0);
                    end else if (is_store) begin
                        case (vsize_reg)
                            irfalu_pkg::SIZE_BYTE: sval_next = {{(DW-8){1'b0}}, pa_reg[7:0]};
                            irfalu_pkg::SIZE_HALF: sval_next = {{(DW-16){1'b0}}, pa_reg[15:0]};
                            default:               sval_next = pa_reg;
                        endcase
                        saddr_next  = operand_reg;
                        svalid_next = store_enable_reg;
                    end else begin
                        bad_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            m_valid_reg      <= 1'b0;
            store_enable_reg <= 1'b0;
            valid_reg        <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                store_enable_reg <= cfg_wr_data;
            end
            if (mem_we) begin
                valid_reg[a_idx_reg] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        vsize_reg   <= vsize_next;
        a_idx_reg   <= a_idx_next;
        b_idx_reg   <= b_idx_next;
        operand_reg <= operand_next;
        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        acc_reg     <= acc_next;
        sval_reg    <= sval_next;
        saddr_reg   <= saddr_next;
        svalid_reg  <= svalid_next;
        dz_reg      <= dz_next;
        bad_reg     <= bad_next;
    end

    // Ports.
    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_store_value    = sval_reg;
    assign m_store_address  = saddr_reg;
    assign m_store_valid    = svalid_reg;
    assign m_divide_by_zero = dz_reg;
    assign m_bad_operation  = bad_reg;

`ifndef SYNTHESIS
    // A result appears only as the sequencer finishes an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the final state");

    // An accepted item always starts with the first register read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_RD_A))
        else $error("accepted item did not start the register read");

    // A marked store never carries an error flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_store_valid) |-> (!m_bad_operation && !m_divide_by_zero))
        else $error("store result carries an error flag");

    // Only multiply and divide iterate beyond the first pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && cnt_reg != '0)
            |-> (op_kind == irfalu_pkg::OP_MUL || op_kind == irfalu_pkg::OP_DIV))
        else $error("single-pass operation iterated");
`endif

endmodule

`default_nettype wire
